/* sv/rcs_pkg.sv */
// rcs_pkg: shared widths, reset values, register indexes and control structs
package rcs_pkg;

    localparam int PULSE_W = 12;
    localparam int BAND_W  = 8;
    localparam int IDX_W   = 3;
    // signed width of the mapping arithmetic (edges reach -255 .. 4350)
    localparam int MAP_W   = 14;
    localparam int PROD_W  = 2 * MAP_W;
    // magnitudes fed to the divider
    localparam int DVD_W   = PROD_W - 1;
    localparam int DVS_W   = MAP_W - 1;

    localparam logic [PULSE_W-1:0] RC_MIN_RST    = 12'd1000;
    localparam logic [PULSE_W-1:0] RC_MID_RST    = 12'd1400;
    localparam logic [PULSE_W-1:0] RC_MAX_RST    = 12'd1880;
    localparam logic [PULSE_W-1:0] CMD_MIN_RST   = 12'd1100;
    localparam logic [PULSE_W-1:0] CMD_MID_RST   = 12'd1500;
    localparam logic [PULSE_W-1:0] CMD_MAX_RST   = 12'd1900;
    localparam logic [BAND_W-1:0]  DEAD_BAND_RST = 8'd15;
    localparam logic [BAND_W-1:0]  SLEW_STEP_RST = 8'd6;

    typedef enum logic [IDX_W-1:0] {
        REG_RC_MIN,
        REG_RC_MID,
        REG_RC_MAX,
        REG_CMD_MIN,
        REG_CMD_MID,
        REG_CMD_MAX,
        REG_DEAD_BAND,
        REG_SLEW_STEP
    } reg_idx_t;

    typedef struct packed {
        logic load_in;
        logic map;
        logic mul;
        logic div_start;
        logic filt;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

endpackage

/* sv/rcs_rc_if.sv */
// rcs_rc_if: channel carrying one measured stick pulse word
interface rcs_rc_if;
    logic                        valid;
    logic                        ready;
    logic [rcs_pkg::PULSE_W-1:0] rc_pulse;

    modport source (output valid, output rc_pulse, input ready);
    modport sink   (input valid, input rc_pulse, output ready);
endinterface

/* sv/rcs_servo_if.sv */
// rcs_servo_if: channel carrying one servo command word
interface rcs_servo_if;
    logic                        valid;
    logic                        ready;
    logic [rcs_pkg::PULSE_W-1:0] servo_pulse;

    modport source (output valid, output servo_pulse, input ready);
    modport sink   (input valid, input servo_pulse, output ready);
endinterface

/* sv/rcs_div.sv */
// rcs_div: restoring unsigned divider, one quotient bit per cycle
module rcs_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rcs_pkg::DVD_W-1:0]   dividend,
    input  logic [rcs_pkg::DVS_W-1:0]   divisor,
    output logic [rcs_pkg::DVD_W-1:0]   quotient,
    output logic                        done
);

    localparam int CNT_W = $clog2(rcs_pkg::DVD_W);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [rcs_pkg::DVD_W-1:0] q_reg, q_next;
    logic [rcs_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [rcs_pkg::DVS_W-1:0] dvs_reg, dvs_next;
    logic [rcs_pkg::DVS_W:0]   trial;

    assign trial = {rem_reg, q_reg[rcs_pkg::DVD_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = rcs_pkg::DVS_W'(trial - {1'b0, dvs_reg});
                q_next   = {q_reg[rcs_pkg::DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[rcs_pkg::DVS_W-1:0];
                q_next   = {q_reg[rcs_pkg::DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(rcs_pkg::DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

/* sv/rcs_ctrl.sv */
// rcs_ctrl: sequencer stepping one word through map, multiply, divide, filter, slew
module rcs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rc_valid,
    output logic              rc_ready,
    output logic              servo_valid,
    input  logic              servo_ready,
    output rcs_pkg::cmd_t     cmd,
    input  rcs_pkg::status_t  st
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_MUL,
        S_DIV,
        S_DIVW,
        S_FILT,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        rc_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                rc_ready = 1'b1;
                if (rc_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MAP;
                end
            end
            S_MAP:
            begin
                cmd.map    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW:
            begin
                if (st.div_done)
                    state_next = S_FILT;
            end
            S_FILT:
            begin
                cmd.filt   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // output word slot must be free before the slew state moves on
                if (!valid_reg || servo_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
            valid_next = 1'b1;
        else if (servo_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign servo_valid = valid_reg;

endmodule

/* sv/rcs_datapath.sv */
// rcs_datapath: config registers, segment map, filter and slew limiter state
module rcs_datapath #(
    parameter int FRACTION_BITS = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rcs_pkg::IDX_W-1:0]     cfg_index,
    input  logic [rcs_pkg::PULSE_W-1:0]   cfg_data,
    input  logic [rcs_pkg::PULSE_W-1:0]   rc_pulse,
    input  rcs_pkg::cmd_t                 cmd,
    output rcs_pkg::status_t              st,
    output logic [rcs_pkg::PULSE_W-1:0]   servo_pulse
);

    localparam int PW    = rcs_pkg::PULSE_W;
    localparam int MW    = rcs_pkg::MAP_W;
    localparam int ACC_W = PW + FRACTION_BITS;
    localparam int DIF_W = ACC_W + 2;

    // configuration
    logic [PW-1:0]              rc_min_reg, rc_mid_reg, rc_max_reg;
    logic [PW-1:0]              cmd_min_reg, cmd_mid_reg, cmd_max_reg;
    logic [rcs_pkg::BAND_W-1:0] dead_band_reg, slew_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_min_reg    <= rcs_pkg::RC_MIN_RST;
            rc_mid_reg    <= rcs_pkg::RC_MID_RST;
            rc_max_reg    <= rcs_pkg::RC_MAX_RST;
            cmd_min_reg   <= rcs_pkg::CMD_MIN_RST;
            cmd_mid_reg   <= rcs_pkg::CMD_MID_RST;
            cmd_max_reg   <= rcs_pkg::CMD_MAX_RST;
            dead_band_reg <= rcs_pkg::DEAD_BAND_RST;
            slew_step_reg <= rcs_pkg::SLEW_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (rcs_pkg::reg_idx_t'(cfg_index))
                rcs_pkg::REG_RC_MIN:    rc_min_reg    <= cfg_data;
                rcs_pkg::REG_RC_MID:    rc_mid_reg    <= cfg_data;
                rcs_pkg::REG_RC_MAX:    rc_max_reg    <= cfg_data;
                rcs_pkg::REG_CMD_MIN:   cmd_min_reg   <= cfg_data;
                rcs_pkg::REG_CMD_MID:   cmd_mid_reg   <= cfg_data;
                rcs_pkg::REG_CMD_MAX:   cmd_max_reg   <= cfg_data;
                rcs_pkg::REG_DEAD_BAND: dead_band_reg <= cfg_data[rcs_pkg::BAND_W-1:0];
                rcs_pkg::REG_SLEW_STEP: slew_step_reg <= cfg_data[rcs_pkg::BAND_W-1:0];
                default:                ;
            endcase
        end
    end

    // map stage
    logic [PW-1:0]        p_reg;
    logic signed [MW-1:0] pin, lo_edge, hi_edge, i1, i2, o1, o2, x;
    logic signed [MW-1:0] xd_reg, od_reg, den_reg, o1_reg;
    logic                 in_dz, lower, mid_reg;

    always_comb
    begin
        pin     = $signed({2'b00, p_reg});
        lo_edge = $signed({2'b00, rc_mid_reg}) - $signed({6'd0, dead_band_reg});
        hi_edge = $signed({2'b00, rc_mid_reg}) + $signed({6'd0, dead_band_reg});
        in_dz   = (pin > lo_edge) && (pin < hi_edge);
        lower   = (pin <= lo_edge);
        if (lower)
        begin
            i1 = $signed({2'b00, rc_min_reg});
            i2 = lo_edge;
            o1 = $signed({2'b00, cmd_min_reg});
            o2 = $signed({2'b00, cmd_mid_reg});
        end
        else
        begin
            i1 = hi_edge;
            i2 = $signed({2'b00, rc_max_reg});
            o1 = $signed({2'b00, cmd_mid_reg});
            o2 = $signed({2'b00, cmd_max_reg});
        end
        // lower bound tested first, so a reversed span can land on either bound
        if (pin < i1)
            x = i1;
        else if (pin > i2)
            x = i2;
        else
            x = pin;
    end

    // multiply and divide
    logic signed [rcs_pkg::PROD_W-1:0] prod_reg, prod_abs;
    logic signed [MW-1:0]              den_abs;
    logic                              q_neg;
    logic [rcs_pkg::DVD_W-1:0]         quotient;
    logic                              div_done;

    assign prod_abs = prod_reg[rcs_pkg::PROD_W-1] ? -prod_reg : prod_reg;
    assign den_abs  = den_reg[MW-1] ? -den_reg : den_reg;
    assign q_neg    = prod_reg[rcs_pkg::PROD_W-1] ^ den_reg[MW-1];

    rcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_abs[rcs_pkg::DVD_W-1:0]),
        .divisor  (den_abs[rcs_pkg::DVS_W-1:0]),
        .quotient (quotient),
        .done     (div_done)
    );

    assign st.div_done = div_done;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            p_reg <= rc_pulse;
        if (cmd.map)
        begin
            xd_reg  <= x - i1;
            od_reg  <= o2 - o1;
            den_reg <= i2 - i1;
            o1_reg  <= o1;
            mid_reg <= in_dz || (i2 == i1);
        end
        if (cmd.mul)
            prod_reg <= xd_reg * od_reg;
    end

    // filter; the mapped target never leaves o1..o2, so 12 quotient bits suffice
    logic signed [MW-1:0]    q_s, tgt_s;
    logic [PW-1:0]           tgt;
    logic [ACC_W-1:0]        acc_reg;
    logic signed [DIF_W-1:0] diff, rnd, inc, acc_sum, half;

    always_comb
    begin
        q_s   = $signed({2'b00, quotient[PW-1:0]});
        if (q_neg)
            q_s = -q_s;
        tgt_s = q_s + o1_reg;
        tgt   = mid_reg ? cmd_mid_reg : tgt_s[PW-1:0];
        half  = DIF_W'(1) <<< (FRACTION_BITS - 1);
        diff  = $signed({2'b00, tgt, {FRACTION_BITS{1'b0}}}) - $signed({2'b00, acc_reg});
        if (diff[DIF_W-1])
            rnd = diff - half;
        else if (diff != '0)
            rnd = diff + half;
        else
            rnd = diff;
        inc     = rnd >>> FRACTION_BITS;
        acc_sum = $signed({2'b00, acc_reg}) + inc;
    end

    // slew limit and final clamp
    logic [PW-1:0]        o_raw, o_sl, o_cl, last_reg, out_reg;
    logic signed [PW:0]   d, stp;

    always_comb
    begin
        o_raw = acc_reg[ACC_W-1:FRACTION_BITS];
        d     = $signed({1'b0, o_raw}) - $signed({1'b0, last_reg});
        stp   = $signed({5'd0, slew_step_reg});
        if (d > stp)
            o_sl = last_reg + PW'(slew_step_reg);
        else if (d < -stp)
            o_sl = last_reg - PW'(slew_step_reg);
        else
            o_sl = o_raw;
        if (o_sl < cmd_min_reg)
            o_cl = cmd_min_reg;
        else if (o_sl > cmd_max_reg)
            o_cl = cmd_max_reg;
        else
            o_cl = o_sl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= ACC_W'(rcs_pkg::CMD_MID_RST) << FRACTION_BITS;
            last_reg <= rcs_pkg::CMD_MID_RST;
        end
        else
        begin
            if (cmd.filt)
                acc_reg <= acc_sum[ACC_W-1:0];
            if (cmd.load_out)
                last_reg <= o_sl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            out_reg <= o_cl;
    end

    assign servo_pulse = out_reg;

endmodule

/* sv/rc_servo_command_shaper.sv */
// rc_servo_command_shaper: stick pulse to servo command with deadzone, filter, slew limit
//
//  channel  | dir  | word         | width
//  ---------+------+--------------+------------------------------
//  rc       | sink | rc_pulse     | 12 unsigned, us
//  servo    | src  | servo_pulse  | 12 unsigned, us
//  cfg      | wr   | cfg_data     | 12, index cfg_index (3 bits)
//
//  Most of the time from an accepted rc word to its servo word is spent in
//  the 27-step restoring divider in rcs_div.
//  One word in flight; a new rc word is taken while the last result waits.
//  Reset loads the default registers and centres filter and slew state.
//  A stalled servo word holds; the next result waits behind it.
module rc_servo_command_shaper #(
    parameter int FRACTION_BITS = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    rcs_rc_if.sink                      rc,
    rcs_servo_if.source                 servo,
    input  logic                        cfg_we,
    input  logic [rcs_pkg::IDX_W-1:0]   cfg_index,
    input  logic [rcs_pkg::PULSE_W-1:0] cfg_data
);

    rcs_pkg::cmd_t    cmd;
    rcs_pkg::status_t st;

    rcs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .rc_valid    (rc.valid),
        .rc_ready    (rc.ready),
        .servo_valid (servo.valid),
        .servo_ready (servo.ready),
        .cmd         (cmd),
        .st          (st)
    );

    rcs_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rc_pulse    (rc.rc_pulse),
        .cmd         (cmd),
        .st          (st),
        .servo_pulse (servo.servo_pulse)
    );

    // one word in flight: no second accept straight after the first
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rc.valid && rc.ready) |=> !rc.ready)
        else $error("rc word accepted while another is in flight");

    // a result only overwrites a free or departing output word
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!servo.valid || servo.ready))
        else $error("servo word overwritten while stalled");

    // divider runs only with the input side closed
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_start || st.div_done) |-> !rc.ready)
        else $error("divider active while input open");

endmodule
